[hdl/psla_pkg.sv]
// Shared types, constants and tables of the PWM synth LFO arpeggiator.
package psla_pkg;

	// Control item, one per control tick
	typedef struct packed {
		logic       mode_default;
		logic       mode_lfo;
		logic       mode_arp;
		logic [2:0] buttons;
		logic [9:0] pot;
		logic       lfo_tick;
	} ctl_item_t;

	// Result item
	typedef struct packed {
		logic [15:0] pwm_period;
		logic [15:0] pwm_compare;
		logic [15:0] lfo_period;
		logic [6:0]  note_letter;
		logic [6:0]  note_accidental;
		logic [1:0]  wave_shape;
	} res_item_t;

	// Chord selection, btn4 over btn3 over btn2
	typedef enum logic [1:0] {
		CHORD_NONE = 2'd0,
		CHORD_BTN2 = 2'd1,
		CHORD_BTN3 = 2'd2,
		CHORD_BTN4 = 2'd3
	} chord_t;

	// Button bit positions
	localparam int unsigned BTN2_BIT = 0;
	localparam int unsigned BTN3_BIT = 1;
	localparam int unsigned BTN4_BIT = 2;

	// Wave shape codes
	localparam logic [1:0] SHAPE_NONE     = 2'd0;
	localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
	localparam logic [1:0] SHAPE_SINE     = 2'd2;

	// Duty fractions, Q0.16
	localparam logic [15:0] DUTY_HALF  = 16'd32768;
	localparam logic [15:0] DUTY_HIGH  = 16'd58982;
	localparam logic [15:0] DUTY_LOW   = 16'd6554;
	localparam logic [15:0] DUTY_STEP  = 16'd166;

	// Reset values
	localparam logic [15:0] TONE_PERIOD_RST = 16'd10000;
	localparam logic [15:0] TICK_PERIOD_RST = 16'd3125;

	// ASCII codes
	localparam logic [6:0] ASCII_SPACE = 7'd32;
	localparam logic [6:0] ASCII_SHARP = 7'd35;
	localparam logic [6:0] ASCII_A     = 7'd65;
	localparam logic [6:0] ASCII_C     = 7'd67;
	localparam logic [6:0] ASCII_D     = 7'd68;
	localparam logic [6:0] ASCII_E     = 7'd69;
	localparam logic [6:0] ASCII_F     = 7'd70;
	localparam logic [6:0] ASCII_G     = 7'd71;

	// floor(pot*64/10) = floor(pot*32*52429 / 2^18), exact over the pot range
	localparam logic [15:0] DIV5_RECIP = 16'd52429;
	localparam int unsigned DIV5_SHIFT = 18;

	// Note periods floor(1e7/f), indexed [chord][note]
	localparam logic [15:0] NOTE_PERIOD [4][3] = '{
		'{16'd34129, 16'd51020, 16'd60975},   // E G D: 293 196 164 Hz
		'{16'd13513, 16'd20242, 16'd25510},   // C# E F#: 740 494 392 Hz
		'{16'd11363, 16'd18050, 16'd22727},   // A C# A: 880 554 440 Hz
		'{16'd30395, 16'd45454, 16'd54054}    // F# A E: 329 220 185 Hz
	};
	localparam logic [6:0] NOTE_LETTER [4][3] = '{
		'{ASCII_E, ASCII_G, ASCII_D},
		'{ASCII_C, ASCII_E, ASCII_F},
		'{ASCII_A, ASCII_C, ASCII_A},
		'{ASCII_F, ASCII_A, ASCII_E}
	};
	localparam logic NOTE_SHARP [4][3] = '{
		'{1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b0},
		'{1'b1, 1'b0, 1'b0}
	};

	// Sine LFO, micro units of 0.5 + 0.4*sin(0.01*i)
	localparam int unsigned SINE_TABLE_LEN = 628;
	localparam logic [19:0] SINE_MICRO [SINE_TABLE_LEN] = '{
		500000, 504000, 507999, 511998, 515996, 519992,
		523986, 527977, 531966, 535951, 539933, 543911, 547885,
		551854, 555817, 559775, 563727, 567673, 571612, 575544,
		579468, 583384, 587292, 591191, 595081, 598962, 602832,
		606693, 610542, 614381, 618208, 622023, 625827, 629617,
		633395, 637159, 640910, 644646, 648368, 652075, 655767,
		659444, 663104, 666748, 670376, 673986, 677579, 681155,
		684712, 688250, 691770, 695271, 698752, 702213, 705654,
		709075, 712474, 715853, 719210, 722544, 725857, 729147,
		732414, 735658, 738878, 742075, 745247, 748394, 751517,
		754615, 757687, 760734, 763754, 766748, 769715, 772656,
		775569, 778454, 781312, 784141, 786942, 789715, 792458,
		795173, 797857, 800512, 803137, 805732, 808296, 810829,
		813331, 815801, 818241, 820648, 823023, 825366, 827677,
		829954, 832199, 834410, 836588, 838733, 840843, 842920,
		844962, 846969, 848942, 850880, 852783, 854651, 856483,
		858279, 860040, 861765, 863453, 865106, 866721, 868300,
		869842, 871348, 872816, 874246, 875640, 876996, 878314,
		879594, 880836, 882040, 883206, 884334, 885423, 886474,
		887486, 888459, 889394, 890289, 891146, 891963, 892741,
		893480, 894180, 894840, 895461, 896042, 896583, 897085,
		897547, 897970, 898352, 898695, 898998, 899261, 899484,
		899667, 899810, 899914, 899977, 900000, 899983, 899926,
		899829, 899693, 899516, 899299, 899043, 898746, 898410,
		898033, 897617, 897161, 896666, 896131, 895556, 894942,
		894288, 893594, 892862, 892090, 891279, 890428, 889539,
		888611, 887644, 886638, 885593, 884510, 883389, 882229,
		881030, 879794, 878520, 877208, 875858, 874471, 873046,
		871584, 870085, 868548, 866975, 865365, 863719, 862036,
		860317, 858562, 856771, 854945, 853083, 851186, 849253,
		847286, 845284, 843247, 841176, 839071, 836932, 834760,
		832553, 830314, 828042, 825736, 823399, 821028, 818626,
		816192, 813726, 811229, 808701, 806142, 803552, 800932,
		798282, 795602, 792893, 790154, 787386, 784589, 781764,
		778911, 776030, 773121, 770185, 767222, 764232, 761216,
		758174, 755106, 752012, 748893, 745750, 742581, 739389,
		736172, 732932, 729669, 726382, 723073, 719742, 716389,
		713014, 709618, 706201, 702763, 699305, 695827, 692329,
		688812, 685277, 681722, 678150, 674560, 670952, 667327,
		663686, 660028, 656354, 652664, 648960, 645240, 641506,
		637757, 633995, 630220, 626431, 622630, 618817, 614991,
		611154, 607306, 603448, 599579, 595700, 591811, 587913,
		584007, 580092, 576169, 572239, 568301, 564356, 560405,
		556448, 552485, 548517, 544544, 540567, 536586, 532601,
		528613, 524621, 520628, 516632, 512635, 508636, 504637,
		500637, 496637, 492637, 488639, 484641, 480645, 476650,
		472658, 468669, 464683, 460701, 456722, 452748, 448778,
		444814, 440855, 436902, 432955, 429015, 425082, 421157,
		417239, 413330, 409429, 405538, 401656, 397784, 393922,
		390070, 386230, 382401, 378583, 374778, 370986, 367206,
		363439, 359687, 355948, 352224, 348514, 344820, 341141,
		337478, 333831, 330201, 326588, 322992, 319414, 315854,
		312312, 308789, 305285, 301801, 298337, 294892, 291468,
		288066, 284684, 281324, 277985, 274669, 271375, 268105,
		264857, 261633, 258433, 255257, 252105, 248978, 245877,
		242801, 239750, 236725, 233727, 230756, 227811, 224894,
		222004, 219141, 216307, 213502, 210725, 207977, 205258,
		202568, 199909, 197279, 194680, 192111, 189573, 187066,
		184590, 182146, 179733, 177353, 175005, 172689, 170406,
		168156, 165940, 163756, 161607, 159491, 157409, 155361,
		153348, 151370, 149426, 147518, 145644, 143806, 142004,
		140238, 138507, 136813, 135155, 133534, 131949, 130401,
		128890, 127416, 125979, 124580, 123218, 121894, 120608,
		119359, 118149, 116977, 115843, 114748, 113691, 112673,
		111693, 110752, 109851, 108988, 108164, 107380, 106635,
		105929, 105262, 104635, 104048, 103500, 102992, 102524,
		102095, 101706, 101357, 101048, 100778, 100549, 100359,
		100210, 100100, 100031, 100001, 100012, 100062, 100152,
		100283, 100453, 100664, 100914, 101204, 101534, 101904,
		102314, 102763, 103252, 103781, 104350, 104958, 105606,
		106293, 107019, 107785, 108590, 109434, 110317, 111239,
		112200, 113199, 114238, 115315, 116430, 117584, 118776,
		120006, 121274, 122581, 123924, 125306, 126725, 128181,
		129674, 131205, 132772, 134376, 136016, 137693, 139407,
		141156, 142941, 144762, 146618, 148510, 150437, 152399,
		154395, 156426, 158492, 160591, 162725, 164892, 167093,
		169327, 171594, 173894, 176227, 178592, 180989, 183418,
		185879, 188371, 190894, 193448, 196033, 198648, 201294,
		203969, 206674, 209408, 212171, 214963, 217784, 220633,
		223509, 226414, 229345, 232304, 235290, 238302, 241340,
		244404, 247493, 250608, 253748, 256912, 260101, 263314,
		266550, 269810, 273093, 276398, 279726, 283076, 286447,
		289840, 293254, 296688, 300143, 303618, 307113, 310626,
		314159, 317710, 321280, 324867, 328472, 332094, 335733,
		339389, 343060, 346747, 350449, 354167, 357899, 361645,
		365405, 369178, 372965, 376764, 380575, 384399, 388234,
		392080, 395937, 399804, 403682, 407569, 411465, 415370,
		419284, 423206, 427135, 431072, 435015, 438965, 442921,
		446883, 450850, 454822, 458799, 462780, 466764, 470752,
		474743, 478736, 482731, 486728, 490727, 494726
	};

endpackage

[hdl/psla_if.sv]
// Valid/ready channel interfaces for control items and result items.
interface psla_ctl_if;
	logic                 valid;
	logic                 ready;
	psla_pkg::ctl_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface psla_res_if;
	logic                 valid;
	logic                 ready;
	psla_pkg::res_item_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/psla_sine_rom.sv]
// Two-port sine duty ROM, Q0.16 entries, registered read data.
module psla_sine_rom #(
	parameter int SINE_STEPS = 628,
	localparam int IDX_W = $clog2(SINE_STEPS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] addr_a,
	input  logic [IDX_W-1:0] addr_b,
	output logic [15:0]      data_a,
	output logic [15:0]      data_b
);
	import psla_pkg::*;

	// Contents after reset: entries 0 and 1
	localparam logic [63:0] MICRO_0 = 64'(SINE_MICRO[0]);
	localparam logic [63:0] MICRO_1 = 64'(SINE_MICRO[1]);
	localparam logic [15:0] ROM_0 = 16'((MICRO_0 * 64'd65536 + 64'd500000) / 64'd1000000);
	localparam logic [15:0] ROM_1 = 16'((MICRO_1 * 64'd65536 + 64'd500000) / 64'd1000000);

	logic [15:0] rom [SINE_STEPS];

	// Table entries, micro units rounded to Q0.16, table repeats past its length
	for (genvar g = 0; g < SINE_STEPS; g++) begin : g_rom
		localparam logic [63:0] MICRO = 64'(SINE_MICRO[g % SINE_TABLE_LEN]);
		localparam logic [15:0] VAL = 16'((MICRO * 64'd65536 + 64'd500000) / 64'd1000000);
		assign rom[g] = VAL;
	end

	// Registered reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_a <= ROM_0;
			data_b <= ROM_1;
		end else begin
			data_a <= rom[addr_a];
			data_b <= rom[addr_b];
		end
	end

endmodule

[hdl/psla_core.sv]
// Synth state and per-tick update: compare, default, LFO and arpeggio logic.
module psla_core #(
	parameter int SINE_STEPS      = 628,
	parameter int NOTE_TICKS      = 10,
	parameter int TRIANGLE_DIVIDE = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  psla_pkg::ctl_item_t item,
	output psla_pkg::res_item_t result
);
	import psla_pkg::*;

	localparam int IDX_W = $clog2(SINE_STEPS);
	localparam int TRI_W = $clog2(TRIANGLE_DIVIDE + 1);
	localparam int ARP_W = $clog2(3 * NOTE_TICKS + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SINE_STEPS - 1);
	localparam logic [TRI_W-1:0] TRI_END  = TRI_W'(TRIANGLE_DIVIDE);
	localparam logic [ARP_W-1:0] NOTE1_END = ARP_W'(NOTE_TICKS);
	localparam logic [ARP_W-1:0] NOTE2_END = ARP_W'(2 * NOTE_TICKS);
	localparam logic [ARP_W-1:0] NOTE3_END = ARP_W'(3 * NOTE_TICKS);

	// State registers
	logic [15:0]      tone_q, tick_q, duty_q;
	logic             pend_q, rising_q, use_tri_q, prev_btn_q;
	logic [TRI_W-1:0] tri_cnt_q;
	logic [IDX_W-1:0] sine_idx_q;
	logic [ARP_W-1:0] arp_cnt_q;
	logic [6:0]       letter_q, accid_q;
	logic [1:0]       shape_q;

	// Next state
	logic [15:0]      tone_d, tick_d, duty_d;
	logic             pend_d, rising_d, use_tri_d, prev_btn_d;
	logic [TRI_W-1:0] tri_cnt_d;
	logic [IDX_W-1:0] sine_idx_d, sine_inc, rom_addr_a, rom_addr_b;
	logic [ARP_W-1:0] arp_cnt_d;
	logic [6:0]       letter_d, accid_d;
	logic [1:0]       shape_d;

	logic [31:0] cmp_prod;
	logic [30:0] tick_prod;
	logic [15:0] pot_x64;
	logic [15:0] rom_cur, rom_nxt;
	chord_t      chord;
	logic [1:0]  note;
	logic        note_set;

	// Sine ROM holds the entries at the current index and the one after it
	psla_sine_rom #(.SINE_STEPS(SINE_STEPS)) u_rom (
		.clk    (clk),
		.arst_n (arst_n),
		.addr_a (rom_addr_a),
		.addr_b (rom_addr_b),
		.data_a (rom_cur),
		.data_b (rom_nxt)
	);

	// Index stays put on cycles without a step, so the ROM keeps the current entries
	assign sine_inc   = (sine_idx_q == IDX_LAST) ? '0 : sine_idx_q + IDX_W'(1);
	assign rom_addr_a = step ? sine_idx_d : sine_idx_q;
	assign rom_addr_b = (rom_addr_a == IDX_LAST) ? '0 : rom_addr_a + IDX_W'(1);

	// Compare from the period and duty before this tick
	assign cmp_prod  = tone_q * duty_q;
	assign pot_x64   = {item.pot, 6'b0};
	assign tick_prod = {item.pot, 5'b0} * DIV5_RECIP;

	// Chord select, btn4 first
	always_comb begin
		priority if (item.buttons[BTN4_BIT]) chord = CHORD_BTN4;
		else if (item.buttons[BTN3_BIT])     chord = CHORD_BTN3;
		else if (item.buttons[BTN2_BIT])     chord = CHORD_BTN2;
		else                                 chord = CHORD_NONE;
	end

	// Mode updates in order: default, LFO, arpeggio
	always_comb begin
		tone_d     = tone_q;
		tick_d     = tick_q;
		duty_d     = duty_q;
		pend_d     = pend_q | item.lfo_tick;
		rising_d   = rising_q;
		use_tri_d  = use_tri_q;
		prev_btn_d = prev_btn_q;
		tri_cnt_d  = tri_cnt_q;
		sine_idx_d = sine_idx_q;
		arp_cnt_d  = arp_cnt_q;
		letter_d   = letter_q;
		accid_d    = accid_q;
		shape_d    = shape_q;
		note       = 2'd0;
		note_set   = 1'b0;

		if (item.mode_default) begin
			tone_d = pot_x64;
			duty_d = DUTY_HALF;
		end

		if (item.mode_lfo) begin
			letter_d   = ASCII_SPACE;
			accid_d    = ASCII_SPACE;
			tone_d     = pot_x64;
			use_tri_d  = use_tri_q ^ (!prev_btn_q && item.buttons[BTN4_BIT]);
			prev_btn_d = item.buttons[BTN4_BIT];
			if (use_tri_d) begin
				shape_d = SHAPE_TRIANGLE;
				if (pend_d) begin
					pend_d    = 1'b0;
					tri_cnt_d = tri_cnt_q + TRI_W'(1);
				end
				if (tri_cnt_d == TRI_END) begin
					tri_cnt_d = '0;
					if (rising_q) begin
						if (duty_d < DUTY_HIGH) duty_d = duty_d + DUTY_STEP;
						else rising_d = 1'b0;
					end else begin
						if (duty_d > DUTY_LOW) duty_d = duty_d - DUTY_STEP;
						else rising_d = 1'b1;
					end
				end
			end else begin
				shape_d = SHAPE_SINE;
				duty_d  = rom_cur;
				if (pend_d) begin
					pend_d     = 1'b0;
					sine_idx_d = sine_inc;
					duty_d     = rom_nxt;
				end
			end
		end

		if (item.mode_arp) begin
			tick_d = {3'b0, tick_prod[DIV5_SHIFT +: 13]};
			if (pend_d) begin
				pend_d    = 1'b0;
				arp_cnt_d = arp_cnt_q + ARP_W'(1);
			end
			priority if (arp_cnt_d < NOTE1_END) begin
				note = 2'd0;
				note_set = 1'b1;
			end else if (arp_cnt_d < NOTE2_END) begin
				note = 2'd1;
				note_set = 1'b1;
			end else if (arp_cnt_d < NOTE3_END) begin
				note = 2'd2;
				note_set = 1'b1;
			end else begin
				arp_cnt_d = '0;
			end
			if (note_set) begin
				tone_d   = NOTE_PERIOD[chord][note];
				letter_d = NOTE_LETTER[chord][note];
				accid_d  = NOTE_SHARP[chord][note] ? ASCII_SHARP : ASCII_SPACE;
			end
		end
	end

	// Result for this tick
	always_comb begin
		result.pwm_period      = tone_d;
		result.pwm_compare     = cmp_prod[31:16];
		result.lfo_period      = tick_d;
		result.note_letter     = letter_d;
		result.note_accidental = accid_d;
		result.wave_shape      = shape_d;
	end

	// State update on each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q     <= TONE_PERIOD_RST;
			tick_q     <= TICK_PERIOD_RST;
			duty_q     <= DUTY_LOW;
			pend_q     <= 1'b0;
			rising_q   <= 1'b0;
			use_tri_q  <= 1'b1;
			prev_btn_q <= 1'b1;
			tri_cnt_q  <= '0;
			sine_idx_q <= '0;
			arp_cnt_q  <= '0;
			letter_q   <= ASCII_A;
			accid_q    <= ASCII_SHARP;
			shape_q    <= SHAPE_NONE;
		end else if (step) begin
			tone_q     <= tone_d;
			tick_q     <= tick_d;
			duty_q     <= duty_d;
			pend_q     <= pend_d;
			rising_q   <= rising_d;
			use_tri_q  <= use_tri_d;
			prev_btn_q <= prev_btn_d;
			tri_cnt_q  <= tri_cnt_d;
			sine_idx_q <= sine_idx_d;
			arp_cnt_q  <= arp_cnt_d;
			letter_q   <= letter_d;
			accid_q    <= accid_d;
			shape_q    <= shape_d;
		end
	end

endmodule

[hdl/pwm_synth_lfo_arpeggiator.sv]
// PWM synth control block top level: input register, update logic, result register.
// One control item per clock, sustained while results are taken: an item waits in the
// input register until the result register is free or being drained, the whole tick
// update (compare multiply, mode logic, LFO and arpeggio counters) is combinational
// from it, and the result is loaded into the output register as the item advances.
// The rate is set by the state update loop; the sine duty table is a ROM read ahead at
// the current and the following index, so its data is ready for the next item. A stalled
// result holds in the output register while one more item waits in the input register.
module pwm_synth_lfo_arpeggiator #(
	parameter int SINE_STEPS      = 628,
	parameter int NOTE_TICKS      = 10,
	parameter int TRIANGLE_DIVIDE = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	psla_ctl_if.sink      ctl,
	psla_res_if.source    res
);
	import psla_pkg::*;

	ctl_item_t item_s1;
	logic      valid_s1;
	logic      valid_q;
	logic      adv;
	res_item_t result;

	// Stage 1 moves when the result register is free or being drained
	assign adv       = valid_s1 && (!valid_q || res.ready);
	assign ctl.ready = !valid_s1 || adv;
	assign res.valid = valid_q;

	psla_core #(
		.SINE_STEPS      (SINE_STEPS),
		.NOTE_TICKS      (NOTE_TICKS),
		.TRIANGLE_DIVIDE (TRIANGLE_DIVIDE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.result (result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.ready) begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid && ctl.ready) begin
			item_s1 <= ctl.data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.data <= result;
		end
	end

endmodule

[hdl/psla_checker.sv]
// Port-level assertions on the result channel, bound to the top level.
module psla_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input psla_pkg::res_item_t out_item
);
	import psla_pkg::*;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Shape code never takes the unused value
	a_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.wave_shape != 2'd3)
		else $error("bad wave shape");

	// Accidental is a sharp or a space
	a_accid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.note_accidental == ASCII_SPACE ||
			out_item.note_accidental == ASCII_SHARP))
		else $error("bad accidental");

	// Blanked letter goes with blanked accidental
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.note_letter == ASCII_SPACE |->
			out_item.note_accidental == ASCII_SPACE)
		else $error("letter blanked without accidental");

	// Timer-3 period stays within pot*6.4 at full-scale pot
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.lfo_period <= 16'd6547)
		else $error("timer-3 period out of range");

endmodule

bind pwm_synth_lfo_arpeggiator psla_checker u_psla_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_item  (res.data)
);

[verif/pwm_synth_lfo_arpeggiator_test.sv]
// Self-checking testbench for the PWM synth control block: stimulus, tick model, result check.
`timescale 1ns / 100ps

module pwm_synth_lfo_arpeggiator_test;
	import psla_pkg::*;

	localparam int SINE_STEPS      = 628;
	localparam int NOTE_TICKS      = 10;
	localparam int TRIANGLE_DIVIDE = 3;
	localparam int IDLE_LIMIT      = 2000;

	// Chord tables: frequency in Hz, shown letter, sharp flag; indexed [chord][note]
	localparam int unsigned CHORD_HZ [4][3] = '{
		'{293, 196, 164}, '{740, 494, 392}, '{880, 554, 440}, '{329, 220, 185}
	};
	localparam logic [6:0] CHORD_NAME [4][3] = '{
		'{ASCII_E, ASCII_G, ASCII_D}, '{ASCII_C, ASCII_E, ASCII_F},
		'{ASCII_A, ASCII_C, ASCII_A}, '{ASCII_F, ASCII_A, ASCII_E}
	};
	localparam bit CHORD_SHARP [4][3] = '{
		'{0, 0, 0}, '{1, 0, 1}, '{0, 1, 0}, '{1, 0, 0}
	};

	typedef struct {
		ctl_item_t item;
		bit        drain_first;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	psla_ctl_if ctl_ch();
	psla_res_if res_ch();

	pwm_synth_lfo_arpeggiator #(
		.SINE_STEPS(SINE_STEPS),
		.NOTE_TICKS(NOTE_TICKS),
		.TRIANGLE_DIVIDE(TRIANGLE_DIVIDE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl_ch),
		.res(res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Model state, values after reset
	logic [15:0] tone_period = TONE_PERIOD_RST;
	logic [15:0] tick_period = TICK_PERIOD_RST;
	logic [15:0] duty = DUTY_LOW;
	logic        tick_pending = 1'b0;
	logic [1:0]  triangle_count = 2'd0;
	logic        triangle_rising = 1'b0;
	logic [9:0]  sine_index = 10'd0;
	logic        use_triangle = 1'b1;
	logic        prev_btn4 = 1'b1;
	logic [4:0]  arp_count = 5'd0;
	logic [6:0]  shown_letter = ASCII_A;
	logic [6:0]  shown_accidental = ASCII_SHARP;
	logic [1:0]  shown_shape = SHAPE_NONE;
	logic [15:0] sine_duty [SINE_STEPS];

	// Bookkeeping
	stim_t     ctl_backlog[$];
	res_item_t due_results[$];
	bit        ctl_took = 1'b0;
	bit        res_took = 1'b0;
	int        items_in = 0;
	int        results_checked = 0;
	int        error_count = 0;
	int        idle_cycles = 0;
	int        triangle_turns = 0;
	int        sine_wraps = 0;
	int        notes_set = 0;
	int        send_gap = 0;
	int        recv_wait = 0;
	bit        send_burst = 1'b0;
	bit        recv_burst = 1'b0;

	// Generator view of the LFO shape toggle, used to steer btn4
	bit gen_triangle = 1'b1;
	bit gen_prev_btn4 = 1'b1;

	// One control tick: returns the result and advances the model state
	function automatic res_item_t advance_tick(ctl_item_t c);
		res_item_t   r;
		logic [31:0] prod;
		logic        btn4;
		chord_t      chord;
		int unsigned note;
		if (c.lfo_tick)
			tick_pending = 1'b1;
		// compare uses period and duty from before the tick
		prod = {16'd0, tone_period} * {16'd0, duty};
		r.pwm_compare = prod[31:16];

		if (c.mode_default) begin
			tone_period = {c.pot, 6'd0};
			duty = DUTY_HALF;
		end

		if (c.mode_lfo) begin
			btn4 = c.buttons[BTN4_BIT];
			shown_letter = ASCII_SPACE;
			shown_accidental = ASCII_SPACE;
			tone_period = {c.pot, 6'd0};
			if (!prev_btn4 && btn4)
				use_triangle = !use_triangle;
			if (use_triangle) begin
				shown_shape = SHAPE_TRIANGLE;
				if (tick_pending) begin
					tick_pending = 1'b0;
					triangle_count = triangle_count + 2'd1;
				end
				if (triangle_count == 2'(TRIANGLE_DIVIDE)) begin
					if (triangle_rising) begin
						if (duty < DUTY_HIGH) begin
							duty = duty + DUTY_STEP;
						end else begin
							triangle_rising = 1'b0;
							triangle_turns++;
						end
					end else begin
						if (duty > DUTY_LOW) begin
							duty = duty - DUTY_STEP;
						end else begin
							triangle_rising = 1'b1;
							triangle_turns++;
						end
					end
					triangle_count = 2'd0;
				end
			end else begin
				shown_shape = SHAPE_SINE;
				if (tick_pending) begin
					tick_pending = 1'b0;
					sine_index = sine_index + 10'd1;
				end
				if (sine_index >= 10'(SINE_STEPS)) begin
					sine_index = 10'd0;
					sine_wraps++;
				end
				duty = sine_duty[sine_index];
			end
			prev_btn4 = btn4;
		end

		if (c.mode_arp) begin
			tick_period = 16'(({16'd0, c.pot, 6'd0}) / 10);
			if (c.buttons[BTN4_BIT])
				chord = CHORD_BTN4;
			else if (c.buttons[BTN3_BIT])
				chord = CHORD_BTN3;
			else if (c.buttons[BTN2_BIT])
				chord = CHORD_BTN2;
			else
				chord = CHORD_NONE;
			// the LFO may already have taken the tick
			if (tick_pending) begin
				tick_pending = 1'b0;
				arp_count = arp_count + 5'd1;
			end
			note = arp_count / NOTE_TICKS;
			if (note < 3) begin
				tone_period = 16'(10000000 / CHORD_HZ[chord][note]);
				shown_letter = CHORD_NAME[chord][note];
				shown_accidental = CHORD_SHARP[chord][note] ? ASCII_SHARP : ASCII_SPACE;
				notes_set++;
			end
			if (arp_count >= 5'(3 * NOTE_TICKS))
				arp_count = 5'd0;
		end

		r.pwm_period = tone_period;
		r.lfo_period = tick_period;
		r.note_letter = shown_letter;
		r.note_accidental = shown_accidental;
		r.wave_shape = shown_shape;
		return r;
	endfunction

	function automatic void report_field(string name, int unsigned want, logic [15:0] got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		error_count++;
	endfunction

	// Stimulus helpers
	function automatic void queue_item(ctl_item_t c, bit drain_first);
		stim_t s;
		s.item = c;
		s.drain_first = drain_first;
		ctl_backlog.push_back(s);
		if (c.mode_lfo) begin
			if (!gen_prev_btn4 && c.buttons[BTN4_BIT])
				gen_triangle = !gen_triangle;
			gen_prev_btn4 = c.buttons[BTN4_BIT];
		end
	endfunction

	function automatic ctl_item_t mk(bit def, bit lfo, bit arp, logic [2:0] btn,
			logic [9:0] pot, bit tick);
		ctl_item_t c;
		c.mode_default = def;
		c.mode_lfo = lfo;
		c.mode_arp = arp;
		c.buttons = btn;
		c.pot = pot;
		c.lfo_tick = tick;
		return c;
	endfunction

	function automatic logic [9:0] pick_pot();
		case ($urandom_range(0, 7))
			0: begin
				return 10'd0;
			end
			1: begin
				return 10'h3FF;
			end
			default: begin
				return 10'($urandom_range(0, 1023));
			end
		endcase
	endfunction

	function automatic ctl_item_t noise_item();
		return mk($urandom_range(0, 3) == 0, $urandom_range(0, 1), $urandom_range(0, 1),
			3'($urandom_range(0, 7)), pick_pot(), $urandom_range(0, 1));
	endfunction

	// btn4 value that keeps (or brings) the LFO on the wanted shape
	function automatic logic steer_btn4(bit want_triangle);
		if (gen_triangle != want_triangle)
			return !gen_prev_btn4;
		if (gen_prev_btn4)
			return 1'($urandom_range(0, 1));
		return 1'b0;
	endfunction

	// Long LFO runs with frequent ticks so the duty sweeps and the sine index wraps
	function automatic void lfo_phase(int n, bit want_triangle);
		ctl_item_t c;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 29) == 0) begin
				c = noise_item();
			end else begin
				c = mk(1'b0, 1'b1, $urandom_range(0, 3) == 0, 3'($urandom_range(0, 3)),
					pick_pot(), $urandom_range(0, 19) != 0);
				c.buttons[BTN4_BIT] = steer_btn4(want_triangle);
			end
			queue_item(c, i == 0);
		end
	endfunction

	// Arpeggio-heavy mix with all mode combinations
	function automatic void mixed_phase(int n);
		ctl_item_t c;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					c = mk(1'b0, 1'b0, 1'b1, 3'($urandom_range(0, 7)), pick_pot(),
						$urandom_range(0, 9) < 7);
				end
				2: begin
					c = mk($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
						3'($urandom_range(0, 7)), pick_pot(), $urandom_range(0, 9) < 7);
				end
				default: begin
					c = noise_item();
				end
			endcase
			queue_item(c, i == 0);
		end
	endfunction

	// Driver: presents items at the falling edge, random gap before each
	always @(negedge clk) begin : drive_ctl
		stim_t nxt;
		if (arst_n) begin
			if (!ctl_ch.valid || ctl_took) begin
				if (send_gap > 0) begin
					send_gap--;
					ctl_ch.valid <= 1'b0;
				end else if (ctl_backlog.size() > 0 &&
						!(ctl_backlog[0].drain_first && due_results.size() != 0)) begin
					nxt = ctl_backlog.pop_front();
					ctl_ch.data <= nxt.item;
					ctl_ch.valid <= 1'b1;
					if ($urandom_range(0, 31) == 0)
						send_burst = !send_burst;
					send_gap = send_burst ? 0 : $urandom_range(0, 16);
				end else begin
					ctl_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result side: random stall after each result
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_took) begin
				if ($urandom_range(0, 31) == 0)
					recv_burst = !recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(0, 16);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: predicts on each accepted item, checks each accepted result
	always @(posedge clk) begin : watch
		res_item_t want;
		res_item_t got;
		if (arst_n) begin
			ctl_took <= ctl_ch.valid && ctl_ch.ready;
			res_took <= res_ch.valid && res_ch.ready;
			if (ctl_ch.valid && ctl_ch.ready) begin
				due_results.push_back(advance_tick(ctl_ch.data));
				items_in++;
			end
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (due_results.size() == 0) begin
					$display("%0t: result with none expected, got period %0d compare %0d",
						$time, got.pwm_period, got.pwm_compare);
					error_count++;
				end else begin
					want = due_results.pop_front();
					if (got.pwm_period !== want.pwm_period)
						report_field("pwm_period", want.pwm_period, got.pwm_period);
					if (got.pwm_compare !== want.pwm_compare)
						report_field("pwm_compare", want.pwm_compare, got.pwm_compare);
					if (got.lfo_period !== want.lfo_period)
						report_field("lfo_period", want.lfo_period, got.lfo_period);
					if (got.note_letter !== want.note_letter)
						report_field("note_letter", want.note_letter, 16'(got.note_letter));
					if (got.note_accidental !== want.note_accidental)
						report_field("note_accidental", want.note_accidental,
							16'(got.note_accidental));
					if (got.wave_shape !== want.wave_shape)
						report_field("wave_shape", want.wave_shape, 16'(got.wave_shape));
				end
				results_checked++;
			end
			// watchdog on cycles with no item moving
			if ((ctl_ch.valid && ctl_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d results outstanding",
					$time, idle_cycles, due_results.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : main
		int     total_items;
		longint m;
		ctl_ch.valid = 1'b0;
		ctl_ch.data = '0;
		res_ch.ready = 1'b0;

		// duty table, micro units to Q0.16, half rounded up
		for (int i = 0; i < SINE_STEPS; i++) begin
			m = SINE_MICRO[i % SINE_TABLE_LEN];
			sine_duty[i] = 16'((m * 65536 + 500000) / 1000000);
		end

		// Directed: reset state, tick latching, each mode alone and together
		queue_item(mk(0, 0, 0, 3'd0, 10'd0, 0), 0);
		queue_item(mk(0, 0, 0, 3'd7, 10'h3FF, 1), 0);     // tick held pending
		queue_item(mk(1, 0, 0, 3'd0, 10'h3FF, 0), 0);
		queue_item(mk(1, 0, 0, 3'd0, 10'd0, 0), 0);
		queue_item(mk(1, 0, 0, 3'd0, 10'd512, 0), 0);
		queue_item(mk(0, 1, 0, 3'd4, 10'h3FF, 0), 0);     // btn4 held from reset: no toggle
		queue_item(mk(0, 1, 0, 3'd0, 10'd700, 1), 0);
		queue_item(mk(0, 1, 0, 3'd0, 10'd700, 1), 0);     // third tick steps the triangle
		queue_item(mk(0, 1, 0, 3'd4, 10'd300, 1), 0);     // press: switch to sine
		queue_item(mk(0, 1, 0, 3'd4, 10'd300, 1), 0);
		queue_item(mk(0, 1, 0, 3'd0, 10'd1, 0), 0);
		queue_item(mk(0, 0, 1, 3'd0, 10'h3FF, 1), 0);
		queue_item(mk(0, 0, 1, 3'd1, 10'd100, 0), 0);
		queue_item(mk(0, 0, 1, 3'd2, 10'd101, 0), 0);
		queue_item(mk(0, 0, 1, 3'd4, 10'd102, 1), 0);
		queue_item(mk(0, 0, 1, 3'd7, 10'd0, 0), 0);
		queue_item(mk(0, 1, 1, 3'd3, 10'd600, 1), 0);     // LFO takes the tick first
		queue_item(mk(1, 1, 1, 3'd7, 10'h3FF, 1), 0);
		queue_item(mk(1, 0, 1, 3'd2, 10'd5, 1), 0);
		queue_item(mk(0, 0, 0, 3'd0, 10'd9, 1), 0);
		queue_item(mk(0, 0, 1, 3'd0, 10'd9, 0), 0);       // pending tick consumed by arpeggio
		queue_item(mk(1, 0, 0, 3'd0, 10'd800, 0), 0);

		// Random: triangle sweep, sine sweep, then arpeggio-heavy mix
		lfo_phase(560, 1'b1);
		lfo_phase(720, 1'b0);
		mixed_phase(300);
		total_items = ctl_backlog.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (items_in < total_items)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d control items, checked %0d results, %0d arpeggio notes set.",
			items_in, results_checked, notes_set);
		$display("Triangle LFO reversed %0d times, sine index wrapped %0d times.",
			triangle_turns, sine_wraps);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
hdl/psla_pkg.sv
hdl/psla_if.sv
hdl/psla_sine_rom.sv
hdl/psla_core.sv
hdl/pwm_synth_lfo_arpeggiator.sv
hdl/psla_checker.sv
verif/pwm_synth_lfo_arpeggiator_test.sv
